[src/osp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osp_pkg
// Shared types and constants of the one-shot sample player and mixer.
// ----------------------------------------------------------------------------
package osp_pkg;

    localparam int DEFAULT_SAMPLE_DEPTH = 65536;

    localparam int STEP_W   = 20;
    localparam int CHAN_W   = 2;
    localparam int FRAMES_W = 17;
    localparam int GAIN_W   = 16;
    localparam int SMP_W    = 16;
    localparam int CUR_W    = 32;
    localparam int BASE_W   = 17;   // frame index times stride, plus one
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [STEP_W-1:0]   STEP_RESET   = 20'd65536;
    localparam logic [CHAN_W-1:0]   CHAN_RESET   = 2'd2;
    localparam logic [FRAMES_W-1:0] FRAMES_RESET = 17'd0;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd27853;   // 0.85 in Q15

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_PLAY = 2'd1,
        OP_MIX  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_STEP        = 2'd0,
        REG_CHANNELS    = 2'd1,
        REG_CLIP_FRAMES = 2'd2,
        REG_GAIN        = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [STEP_W-1:0]   step;
        logic [CHAN_W-1:0]   chan;
        logic [FRAMES_W-1:0] clip;
        logic [GAIN_W-1:0]   gain;
    } osp_cfg_t;

    // per-frame control handed from the cursor to the mix pipeline
    typedef struct packed {
        logic hit;      // clip sample is added to this frame
        logic stereo;   // right side comes from the odd address
        logic still;    // clip still playing after this frame
    } osp_ctl_t;

endpackage

[src/oneshot_sample_player_mixer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oneshot_sample_player_mixer
// One-shot clip player mixed into a stereo stream, APB configured.
// ----------------------------------------------------------------------------
// A mix item passes through stage 1, stage 2 and the output register of osp_mix
// before m_tvalid rises. One item per cycle while s_tready is high; output
// back-pressure can hold it low. Load and play items give no result.
// The sample memory read and the gain multiply set the depth. Reset clears the
// cursor, play flag and pipeline valids and sets the config registers to their defaults;
// the sample memory is not cleared and must be loaded before it is played.
module oneshot_sample_player_mixer
#(
    parameter int SAMPLE_DEPTH = osp_pkg::DEFAULT_SAMPLE_DEPTH   // power of two
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,    // load_index, load_value, in_left, in_right
    input  logic [1:0]                  s_tuser,    // op
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [39:0]                 m_tdata,    // out_left, out_right, still_playing, pad
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [osp_pkg::APB_AW-1:0]  paddr,
    input  logic [osp_pkg::APB_DW-1:0]  pwdata,
    output logic [osp_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import osp_pkg::*;

    osp_cfg_t          cfg;
    osp_ctl_t          ctl;
    op_t               op;
    logic              acc;
    logic              mix_acc;
    logic              load_acc;
    logic [BASE_W-1:0] base;
    logic [SMP_W-1:0]  rd_a;
    logic [SMP_W-1:0]  rd_b;
    logic [SMP_W-1:0]  out_left;
    logic [SMP_W-1:0]  out_right;
    logic              still_playing;

    assign op       = op_t'(s_tuser);
    assign acc      = s_tvalid && s_tready;
    assign mix_acc  = acc && (op == OP_MIX);
    assign load_acc = acc && (op == OP_LOAD);

    osp_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    osp_cursor u_cursor
    (
        .clk   (clk),
        .rst_n (rst_n),
        .acc   (acc),
        .op    (op),
        .cfg   (cfg),
        .ctl   (ctl),
        .base  (base)
    );

    osp_store #(.SAMPLE_DEPTH(SAMPLE_DEPTH)) u_store
    (
        .clk      (clk),
        .wr_en    (load_acc),
        .wr_index (s_tdata[15:0]),
        .wr_data  (s_tdata[31:16]),
        .rd_en    (mix_acc),
        .rd_base  (base),
        .rd_a     (rd_a),
        .rd_b     (rd_b)
    );

    osp_mix u_mix
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .mix_acc       (mix_acc),
        .ctl           (ctl),
        .in_left       (s_tdata[47:32]),
        .in_right      (s_tdata[63:48]),
        .rd_a          (rd_a),
        .rd_b          (rd_b),
        .gain          (cfg.gain),
        .ready         (s_tready),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_left      (out_left),
        .out_right     (out_right),
        .still_playing (still_playing)
    );

    assign m_tdata = {7'd0, still_playing, out_right, out_left};

endmodule

[src/osp_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osp_cfg
// APB register file: step, channel count, clip length and gain.
// ----------------------------------------------------------------------------
module osp_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [osp_pkg::APB_AW-1:0]  paddr,
    input  logic [osp_pkg::APB_DW-1:0]  pwdata,
    output logic [osp_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output osp_pkg::osp_cfg_t           cfg
);
    import osp_pkg::*;

    logic [STEP_W-1:0]   step_reg;
    logic [CHAN_W-1:0]   chan_reg;
    logic [FRAMES_W-1:0] clip_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic                wr_en;
    reg_idx_t            idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
            chan_reg <= CHAN_RESET;
            clip_reg <= FRAMES_RESET;
            gain_reg <= GAIN_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_STEP:        step_reg <= pwdata[STEP_W-1:0];
                REG_CHANNELS:    chan_reg <= pwdata[CHAN_W-1:0];
                REG_CLIP_FRAMES: clip_reg <= pwdata[FRAMES_W-1:0];
                REG_GAIN:        gain_reg <= pwdata[GAIN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_STEP:        prdata = APB_DW'(step_reg);
            REG_CHANNELS:    prdata = APB_DW'(chan_reg);
            REG_CLIP_FRAMES: prdata = APB_DW'(clip_reg);
            REG_GAIN:        prdata = APB_DW'(gain_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.step = step_reg;
    assign cfg.chan = chan_reg;
    assign cfg.clip = clip_reg;
    assign cfg.gain = gain_reg;

endmodule

[src/osp_cursor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osp_cursor
// 16.16 playback cursor, play flag and clip fetch address per mix item.
// ----------------------------------------------------------------------------
module osp_cursor
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        acc,
    input  osp_pkg::op_t                op,
    input  osp_pkg::osp_cfg_t           cfg,
    output osp_pkg::osp_ctl_t           ctl,
    output logic [osp_pkg::BASE_W-1:0]  base
);
    import osp_pkg::*;

    logic [CUR_W-1:0] cursor_reg;
    logic [CUR_W-1:0] cursor_next;
    logic             playing_reg;
    logic             playing_next;
    logic [15:0]      frame;
    logic             end_hit;
    logic [CUR_W:0]   sum;

    assign frame   = cursor_reg[CUR_W-1:16];
    assign end_hit = {1'b0, frame} >= cfg.clip;
    assign sum     = {1'b0, cursor_reg} + (CUR_W+1)'(cfg.step);

    assign ctl.stereo = cfg.chan[1];
    assign ctl.hit    = playing_reg && !end_hit;
    assign ctl.still  = ctl.hit && !sum[CUR_W];
    assign base       = cfg.chan[1] ? {frame, 1'b0} : {1'b0, frame};

    always_comb
    begin
        cursor_next  = cursor_reg;
        playing_next = playing_reg;
        if (acc)
        begin
            unique case (op)
                OP_PLAY:
                begin
                    if (cfg.clip != '0)
                    begin
                        cursor_next  = '0;
                        playing_next = 1'b1;
                    end
                end
                OP_MIX:
                begin
                    if (playing_reg)
                    begin
                        // end of clip or cursor carry-out both stop playback
                        if (ctl.still)
                        begin
                            cursor_next = sum[CUR_W-1:0];
                        end
                        else
                        begin
                            cursor_next  = '0;
                            playing_next = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg  <= '0;
            playing_reg <= 1'b0;
        end
        else
        begin
            cursor_reg  <= cursor_next;
            playing_reg <= playing_next;
        end
    end

    a_idle_cursor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !playing_reg |-> cursor_reg == '0)
        else $error("cursor nonzero while idle");

    a_start_by_play: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(playing_reg) |-> $past(acc && op == OP_PLAY))
        else $error("playback started without a play item");

    a_idle_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        !playing_reg |-> !ctl.hit && !ctl.still)
        else $error("clip fetch flagged while idle");

endmodule

[src/osp_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osp_store
// Clip sample memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module osp_store
#(
    parameter int SAMPLE_DEPTH = osp_pkg::DEFAULT_SAMPLE_DEPTH   // power of two
)
(
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [15:0]                 wr_index,
    input  logic [osp_pkg::SMP_W-1:0]   wr_data,
    input  logic                        rd_en,
    input  logic [osp_pkg::BASE_W-1:0]  rd_base,
    output logic [osp_pkg::SMP_W-1:0]   rd_a,
    output logic [osp_pkg::SMP_W-1:0]   rd_b
);
    import osp_pkg::*;

    localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
    localparam int EXT_W  = (ADDR_W > BASE_W) ? ADDR_W : BASE_W;

    logic [SMP_W-1:0]  sample_mem [SAMPLE_DEPTH];
    logic [SMP_W-1:0]  rd_a_reg;
    logic [SMP_W-1:0]  rd_b_reg;
    logic [EXT_W-1:0]  wr_ext;
    logic [EXT_W-1:0]  ra_ext;
    logic [EXT_W-1:0]  rb_ext;
    logic [ADDR_W-1:0] wa;
    logic [ADDR_W-1:0] ra;
    logic [ADDR_W-1:0] rb;

    // addresses wrap modulo the depth
    assign wr_ext = EXT_W'(wr_index);
    assign ra_ext = EXT_W'(rd_base);
    assign rb_ext = EXT_W'(rd_base) + EXT_W'(1);
    assign wa     = wr_ext[ADDR_W-1:0];
    assign ra     = ra_ext[ADDR_W-1:0];
    assign rb     = rb_ext[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sample_mem[wa] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= sample_mem[ra];
            rd_b_reg <= sample_mem[rb];
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

[src/osp_mix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osp_mix
// Gain multiply, truncation toward zero, add and saturate; output register.
// ----------------------------------------------------------------------------
module osp_mix
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        mix_acc,
    input  osp_pkg::osp_ctl_t           ctl,
    input  logic [osp_pkg::SMP_W-1:0]   in_left,
    input  logic [osp_pkg::SMP_W-1:0]   in_right,
    input  logic [osp_pkg::SMP_W-1:0]   rd_a,
    input  logic [osp_pkg::SMP_W-1:0]   rd_b,
    input  logic [osp_pkg::GAIN_W-1:0]  gain,
    output logic                        ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [osp_pkg::SMP_W-1:0]   out_left,
    output logic [osp_pkg::SMP_W-1:0]   out_right,
    output logic                        still_playing
);
    import osp_pkg::*;

    // stage 1: control and stream frame, aligned with the memory read data
    logic              s1_v_reg;
    osp_ctl_t          s1_ctl_reg;
    logic [SMP_W-1:0]  s1_l_reg;
    logic [SMP_W-1:0]  s1_r_reg;
    // stage 2: products
    logic              s2_v_reg;
    logic              s2_still_reg;
    logic signed [31:0] s2_pl_reg;
    logic signed [31:0] s2_pr_reg;
    logic [SMP_W-1:0]  s2_l_reg;
    logic [SMP_W-1:0]  s2_r_reg;
    // stage 3: result
    logic              o_v_reg;
    logic [SMP_W-1:0]  o_l_reg;
    logic [SMP_W-1:0]  o_r_reg;
    logic              o_still_reg;

    logic              o_en;
    logic              s2_en;
    logic              s1_en;
    logic signed [SMP_W-1:0] smp_l;
    logic signed [SMP_W-1:0] smp_r;
    logic signed [16:0] gain_s;
    logic signed [32:0] pl_full;
    logic signed [32:0] pr_full;
    logic [SMP_W-1:0]  mix_l;
    logic [SMP_W-1:0]  mix_r;

    function automatic logic [SMP_W-1:0] mix_sat(input logic signed [31:0] p,
                                                 input logic [SMP_W-1:0] x);
        logic signed [31:0] adj;
        logic signed [16:0] q;
        logic signed [17:0] s;
        // bias negatives so the arithmetic shift truncates toward zero
        adj = p + (p[31] ? 32'sd32767 : 32'sd0);
        q   = adj[31:15];
        s   = {{2{x[SMP_W-1]}}, x} + {q[16], q};
        if (s > 18'sd32767)
        begin
            mix_sat = 16'h7FFF;
        end
        else if (s < -18'sd32768)
        begin
            mix_sat = 16'h8000;
        end
        else
        begin
            mix_sat = s[SMP_W-1:0];
        end
    endfunction

    assign o_en  = !o_v_reg || out_ready;
    assign s2_en = !s2_v_reg || o_en;
    assign s1_en = !s1_v_reg || s2_en;
    assign ready = s1_en;

    assign smp_l   = s1_ctl_reg.hit ? signed'(rd_a) : '0;
    assign smp_r   = !s1_ctl_reg.hit ? '0 : (s1_ctl_reg.stereo ? signed'(rd_b) : signed'(rd_a));
    assign gain_s  = signed'({1'b0, gain});
    assign pl_full = smp_l * gain_s;
    assign pr_full = smp_r * gain_s;

    assign mix_l = mix_sat(s2_pl_reg, s2_l_reg);
    assign mix_r = mix_sat(s2_pr_reg, s2_r_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_v_reg <= mix_acc;
            end
            if (s2_en)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (o_en)
            begin
                o_v_reg <= s2_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && mix_acc)
        begin
            s1_ctl_reg <= ctl;
            s1_l_reg   <= in_left;
            s1_r_reg   <= in_right;
        end
        if (s2_en && s1_v_reg)
        begin
            s2_still_reg <= s1_ctl_reg.still;
            s2_pl_reg    <= pl_full[31:0];
            s2_pr_reg    <= pr_full[31:0];
            s2_l_reg     <= s1_l_reg;
            s2_r_reg     <= s1_r_reg;
        end
        if (o_en && s2_v_reg)
        begin
            o_l_reg     <= mix_l;
            o_r_reg     <= mix_r;
            o_still_reg <= s2_still_reg;
        end
    end

    assign out_valid     = o_v_reg;
    assign out_left      = o_l_reg;
    assign out_right     = o_r_reg;
    assign still_playing = o_still_reg;

    a_miss_not_still: assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg && !s1_ctl_reg.hit |-> !s1_ctl_reg.still)
        else $error("still_playing set on a pass-through frame");

    a_miss_zero_prod: assert property (@(posedge clk) disable iff (!rst_n)
        s2_en && s1_v_reg && !s1_ctl_reg.hit |=> s2_pl_reg == '0 && s2_pr_reg == '0)
        else $error("clip product nonzero on a pass-through frame");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({o_l_reg, o_r_reg, o_still_reg}))
        else $error("result changed while stalled");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the one-shot sample player and mixer. Items are
// streamed in with random gaps while results are drained with random
// back-pressure, including one long receiver hold-off. Every accepted item
// also runs through a predictor of the player. Each mixed frame is compared
// field by field with the oldest predicted frame. Directed cases cover
// pass-through, saturation, truncation, mono and stereo clips, zero step and
// end of clip. A stereo clip at an eight-frame step skips frames.
// Random phases then vary all four registers.
// ----------------------------------------------------------------------------
module testbench;

    import osp_pkg::*;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 4;      // pipeline is 3 deep
    localparam int         HOLD_OFF       = 300;

    typedef struct packed {
        logic [15:0] out_l;
        logic [15:0] out_r;
        logic        still;
    } mixed_frame_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [63:0]         s_tdata   = '0;
    logic [1:0]          s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [39:0]         m_tdata;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [APB_AW-1:0]   paddr     = '0;
    logic [APB_DW-1:0]   pwdata    = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // predictor state
    logic [15:0]         clip_mem [0:65535];
    logic [31:0]         cursor   = '0;
    logic                playing  = 1'b0;
    logic [STEP_W-1:0]   cfg_step = STEP_RESET;
    logic [CHAN_W-1:0]   cfg_chan = CHAN_RESET;
    logic [FRAMES_W-1:0] cfg_clip = FRAMES_RESET;
    logic [GAIN_W-1:0]   cfg_gain = GAIN_RESET;

    mixed_frame_t        expected_frames[$];

    int                  errors          = 0;
    int                  items_sent      = 0;
    int                  results_checked = 0;
    int                  frames_sounding = 0;
    int                  hold_cycles     = 0;
    bit                  no_gaps         = 1'b0;

    oneshot_sample_player_mixer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    function automatic logic [15:0] sat16(input longint v);
        if (v < -32768)
            return 16'h8000;
        if (v > 32767)
            return 16'h7FFF;
        return v[15:0];
    endfunction

    // Q15 gain on a stored sample, truncating toward zero
    function automatic longint scaled_sample(input logic [15:0] addr);
        longint s;
        s = longint'($signed(clip_mem[addr]));
        return (s * longint'(cfg_gain)) / 32768;
    endfunction

    function automatic void advance_player(input logic [1:0] op, input logic [15:0] idx,
                                           input logic [15:0] val, input logic [15:0] in_l,
                                           input logic [15:0] in_r);
        mixed_frame_t res;
        longint       acc_l;
        longint       acc_r;
        longint       smp_l;
        longint       smp_r;
        logic [16:0]  frame_no;
        logic [17:0]  base_addr;
        logic [32:0]  nxt_cursor;
        logic         stereo;
        if (op == OP_LOAD)
            clip_mem[idx] = val;
        else if (op == OP_PLAY)
        begin
            if (cfg_clip != 0)
            begin
                cursor  = '0;
                playing = 1'b1;
            end
        end
        else if (op == OP_MIX)
        begin
            acc_l     = longint'($signed(in_l));
            acc_r     = longint'($signed(in_r));
            res.still = 1'b0;
            if (playing)
            begin
                frame_no = {1'b0, cursor[31:16]};
                if (frame_no >= cfg_clip)
                begin
                    playing = 1'b0;
                    cursor  = '0;
                end
                else
                begin
                    stereo    = (cfg_chan >= 2);
                    base_addr = stereo ? {frame_no, 1'b0} : {1'b0, frame_no};
                    smp_l     = scaled_sample(base_addr[15:0]);
                    smp_r     = stereo ? scaled_sample(base_addr[15:0] + 16'd1) : smp_l;
                    acc_l     = acc_l + smp_l;
                    acc_r     = acc_r + smp_r;
                    frames_sounding++;
                    nxt_cursor = {1'b0, cursor} + 33'(cfg_step);
                    // carry out of the cursor stops the clip on this frame
                    if (nxt_cursor[32])
                    begin
                        playing = 1'b0;
                        cursor  = '0;
                    end
                    else
                    begin
                        cursor    = nxt_cursor[31:0];
                        res.still = 1'b1;
                    end
                end
            end
            res.out_l = sat16(acc_l);
            res.out_r = sat16(acc_r);
            expected_frames.push_back(res);
        end
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Valid stays high after acceptance; the caller either sends the next
    // item or calls quiesce in the same time step.
    task automatic send_item(input logic [1:0] op, input logic [15:0] idx,
                             input logic [15:0] val, input logic [15:0] in_l,
                             input logic [15:0] in_r);
        while (!no_gaps && $urandom_range(0, 99) < 10)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {in_r, in_l, val, idx};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        advance_player(op, idx, val, in_l, in_r);
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_STEP:        cfg_step = val[STEP_W-1:0];
            REG_CHANNELS:    cfg_chan = val[CHAN_W-1:0];
            REG_CLIP_FRAMES: cfg_clip = val[FRAMES_W-1:0];
            REG_GAIN:        cfg_gain = val[GAIN_W-1:0];
        endcase
        @(posedge clk);
    endtask

    task automatic set_player(input logic [31:0] step, input logic [31:0] chan,
                              input logic [31:0] clip, input logic [31:0] gain);
        quiesce();
        apb_write(REG_STEP, step);
        apb_write(REG_CHANNELS, chan);
        apb_write(REG_CLIP_FRAMES, clip);
        apb_write(REG_GAIN, gain);
    endtask

    // reset config: idle frames pass through, play on an empty clip is dropped
    task automatic test_idle_passthrough();
        send_item(OP_LOAD, 16'hFFFF, 16'h8000, 16'h0000, 16'h0000);
        send_item(OP_MIX, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000);
        send_item(OP_PLAY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(OP_MIX, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF);
        quiesce();
    endtask

    task automatic test_stereo_saturation();
        set_player(32'd65536, 32'd2, 32'd2, 32'd32768);
        send_item(OP_LOAD, 16'd0, 16'h7FFF, 16'h0, 16'h0);
        send_item(OP_LOAD, 16'd1, 16'h8000, 16'h0, 16'h0);
        send_item(OP_LOAD, 16'd2, 16'hFFFF, 16'h0, 16'h0);
        send_item(OP_LOAD, 16'd3, 16'h0001, 16'h0, 16'h0);
        send_item(OP_PLAY, 16'h0, 16'h0, 16'h0, 16'h0);
        send_item(OP_MIX, 16'h0, 16'h0, 16'h7FFF, 16'h8000);
        send_item(OP_MIX, 16'h0, 16'h0, 16'h0001, 16'hFFFF);
        // cursor at clip end: frame passes through
        send_item(OP_MIX, 16'h0, 16'h0, 16'h1234, 16'hEDCB);
        quiesce();
    endtask

    task automatic test_mono_and_step();
        set_player(32'd0, 32'd1, 32'd1, 32'd27853);
        send_item(OP_LOAD, 16'd0, 16'hFFFF, 16'h0, 16'h0);
        send_item(OP_PLAY, 16'h0, 16'h0, 16'h0, 16'h0);
        send_item(OP_MIX, 16'h0, 16'h0, 16'h0100, 16'hFF00);
        send_item(OP_MIX, 16'h0, 16'h0, 16'h8000, 16'h7FFF);
        // shrinking the clip under a stalled cursor ends playback
        quiesce();
        apb_write(REG_CLIP_FRAMES, 32'd0);
        send_item(OP_MIX, 16'h0, 16'h0, 16'h0042, 16'h0024);
        // channel count 3 reads as stereo
        quiesce();
        apb_write(REG_CHANNELS, 32'd3);
        apb_write(REG_CLIP_FRAMES, 32'd1);
        apb_write(REG_STEP, 32'd1);
        send_item(OP_LOAD, 16'd1, 16'h8000, 16'h0, 16'h0);
        send_item(OP_PLAY, 16'h0, 16'h0, 16'h0, 16'h0);
        send_item(OP_MIX, 16'h0, 16'h0, 16'h0000, 16'h0000);
        send_item(OP_MIX, 16'h0, 16'h0, 16'h8000, 16'h8000);
        // channel count 0 reads as mono
        quiesce();
        apb_write(REG_CHANNELS, 32'd0);
        send_item(OP_PLAY, 16'h0, 16'h0, 16'h0, 16'h0);
        send_item(OP_MIX, 16'h0, 16'h0, 16'h7FFF, 16'h0000);
        quiesce();
    endtask

    // Stereo clip at an eight-frame step: the cursor advances eight frames, skipping
    // seven, per mixed frame until it runs past the clip end.
    task automatic test_large_step();
        int k;
        set_player(32'd524288, 32'd2, 32'd64, $urandom_range(0, 32768));
        no_gaps = 1'b1;
        for (k = 0; k < 8; k++)
        begin
            send_item(OP_LOAD, 16'(16 * k), rand_sample(), 16'($urandom), 16'($urandom));
            send_item(OP_LOAD, 16'(16 * k + 1), rand_sample(), 16'($urandom), 16'($urandom));
        end
        send_item(OP_PLAY, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        for (k = 0; k < 10; k++)
            send_item(OP_MIX, 16'($urandom), 16'($urandom), rand_sample(), rand_sample());
        quiesce();
        no_gaps = 1'b0;
    endtask

    task automatic test_backpressure();
        int k;
        set_player(32'd16384, 32'd2, 32'd2, 32'd30000);
        send_item(OP_PLAY, 16'h0, 16'h0, 16'h0, 16'h0);
        hold_cycles = HOLD_OFF;
        for (k = 0; k < 48; k++)
        begin
            if (k == 20)
                send_item(OP_PLAY, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            send_item(OP_MIX, 16'($urandom), 16'($urandom), rand_sample(), rand_sample());
        end
        quiesce();
    endtask

    task automatic test_random_traffic();
        int          phase;
        int          sent;
        int          sel;
        int          max_clip;
        logic [1:0]  chan;
        logic [31:0] step;
        logic [31:0] gain;
        logic [15:0] idx;
        quiesce();
        // random phases only read entries 0..63; fill them first
        for (sel = 0; sel < 64; sel++)
            send_item(OP_LOAD, 16'(sel), rand_sample(), 16'($urandom), 16'($urandom));
        for (phase = 0; phase < 6; phase++)
        begin
            chan     = 2'($urandom_range(0, 3));
            max_clip = (chan >= 2) ? 32 : 64;
            case ($urandom_range(0, 5))
                0:       step = 32'd0;
                1:       step = 32'd1;
                2:       step = 32'd524288;
                default: step = $urandom_range(4096, 131072);
            endcase
            case ($urandom_range(0, 3))
                0:       gain = 32'd0;
                1:       gain = 32'd32768;
                default: gain = $urandom_range(0, 32768);
            endcase
            set_player(step, 32'(chan), $urandom_range(0, max_clip), gain);
            no_gaps = (phase == 3);
            sent    = 0;
            while (sent < 60)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 20)
                begin
                    idx = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 63))
                                                      : 16'($urandom);
                    send_item(OP_LOAD, idx, rand_sample(), 16'($urandom), 16'($urandom));
                end
                else if (sel < 28)
                    send_item(OP_PLAY, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom));
                else if (sel < 97)
                    send_item(OP_MIX, 16'($urandom), 16'($urandom), rand_sample(),
                              rand_sample());
                else
                    send_item(OP_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom));
                if (sel < 97)
                    sent++;
            end
        end
        quiesce();
        no_gaps = 1'b0;
    endtask

    // result side: random back-pressure, long hold-off on request
    always @(posedge clk)
    begin
        mixed_frame_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_checked++;
                if (expected_frames.size() == 0)
                begin
                    $error("mixed frame arrived with no expectation waiting");
                    errors++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (m_tdata[15:0] !== want.out_l)
                    begin
                        $error("out_left mismatch: expected %0d, actual %0d",
                               $signed(want.out_l), $signed(m_tdata[15:0]));
                        errors++;
                    end
                    if (m_tdata[31:16] !== want.out_r)
                    begin
                        $error("out_right mismatch: expected %0d, actual %0d",
                               $signed(want.out_r), $signed(m_tdata[31:16]));
                        errors++;
                    end
                    if (m_tdata[32] !== want.still)
                    begin
                        $error("still_playing mismatch: expected %0d, actual %0d",
                               want.still, m_tdata[32]);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= no_gaps || ($urandom_range(0, 99) >= 10);
        end
    end

    // watchdog: cycles in a row with no handshake on either stream
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_passthrough();
        test_stereo_saturation();
        test_mono_and_step();
        test_large_step();
        test_backpressure();
        test_random_traffic();
        quiesce();
        repeat (8) @(posedge clk);
        if (expected_frames.size() != 0)
        begin
            $error("%0d mixed frames never arrived", expected_frames.size());
            errors++;
        end
        $display("summary: %0d items accepted, %0d mixed frames checked, %0d with clip audible",
                 items_sent, results_checked, frames_sounding);
        $display("summary: directed cases, largest step, long stall, 6 random phases");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
